// File: hdl/sts_pkg.sv
// Package for the sorted table binary search block.
// Holds the item types, the state encoding and the shared constants.
// Used by every module in this project but sts_ram; depends on nothing.
package sts_pkg;

   localparam int DEPTH_DEFAULT = 1024;
   localparam int INDEX_W = 10;
   localparam int DATA_W = 32;
   localparam int COUNT_W = 11;
   localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 11'd1024;

   typedef enum logic [0:0] {
      REQ_LOAD = 1'b0,
      REQ_SEARCH = 1'b1
   } req_kind_type;

   typedef struct packed {
      req_kind_type req_type;
      logic [INDEX_W-1:0] entry_index;
      logic signed [DATA_W-1:0] data_value;
   } req_item_type;

   typedef struct packed {
      logic found;
      logic [INDEX_W-1:0] position;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_PROBE,
      ST_DONE
   } state_type;

endpackage

// File: hdl/sts_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Width and depth are parameters; no dependencies.
module sts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(DEPTH)-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic rd_en,
   input logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/sts_search.sv
// Search engine: request handshake, table write port and the probe sequencer.
// Depends on sts_pkg; drives the ports of one sts_ram instance.
module sts_search #(
   parameter int DEPTH = sts_pkg::DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input sts_pkg::req_item_type req_item,
   input logic [sts_pkg::COUNT_W-1:0] entry_count,
   output logic wr_en,
   output logic [$clog2(DEPTH)-1:0] wr_addr,
   output logic [sts_pkg::DATA_W-1:0] wr_data,
   output logic [$clog2(DEPTH)-1:0] rd_addr,
   input logic [sts_pkg::DATA_W-1:0] rd_data,
   output logic res_valid,
   output sts_pkg::rsp_item_type res_item,
   input logic res_free
);

   import sts_pkg::*;

   localparam int AW = $clog2(DEPTH);

   state_type state_ff, state_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic [AW-1:0] lo_ff, lo_in;
   logic [AW-1:0] hi_ff, hi_in;
   logic [AW-1:0] mid_ff, mid_in;
   logic signed [DATA_W-1:0] hival_ff, hival_in;
   logic found_ff, found_in;
   logic [AW-1:0] pos_ff, pos_in;

   logic accept;
   logic [31:0] cnt_wide;
   logic [31:0] last_wide;
   logic [AW-1:0] last_idx;
   logic [31:0] idx_wide;
   logic signed [DATA_W-1:0] rdv;
   logic gt;
   logic [AW-1:0] lo_n, hi_n;
   logic signed [DATA_W-1:0] hv_n;
   logic [AW:0] sum_n;
   logic [31:0] pos_wide;

   assign accept = req_valid && req_ready;
   assign idx_wide = {{(32 - INDEX_W){1'b0}}, req_item.entry_index};
   assign cnt_wide = {{(32 - COUNT_W){1'b0}}, entry_count};
   assign rdv = $signed(rd_data);

   always_comb begin
      if (cnt_wide == 32'd0) begin
         last_wide = 32'd0;
      end else if (cnt_wide > 32'(DEPTH)) begin
         last_wide = 32'(DEPTH - 1);
      end else begin
         last_wide = cnt_wide - 32'd1;
      end
   end

   assign last_idx = last_wide[AW-1:0];

   assign wr_en = accept && (req_item.req_type == REQ_LOAD) && (idx_wide < 32'(DEPTH));
   assign wr_addr = idx_wide[AW-1:0];
   assign wr_data = req_item.data_value;

   always_comb begin
      gt = key_ff > rdv;
      lo_n = gt ? mid_ff : lo_ff;
      hi_n = gt ? hi_ff : mid_ff;
      hv_n = gt ? hival_ff : rdv;
      sum_n = {1'b0, lo_n} + {1'b0, hi_n};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      key_ff <= key_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      mid_ff <= mid_in;
      hival_ff <= hival_in;
      found_ff <= found_in;
      pos_ff <= pos_in;
   end

   always_comb begin
      state_in = state_ff;
      key_in = key_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      mid_in = mid_ff;
      hival_in = hival_ff;
      found_in = found_ff;
      pos_in = pos_ff;
      rd_addr = mid_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            rd_addr = '0;
            if (accept && (req_item.req_type == REQ_SEARCH)) begin
               key_in = req_item.data_value;
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            rd_addr = last_idx;
            if (key_ff < rdv) begin
               found_in = 1'b0;
               pos_in = '0;
               state_in = ST_DONE;
            end else if (key_ff == rdv) begin
               found_in = 1'b1;
               pos_in = '0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            lo_in = '0;
            hi_in = last_idx;
            hival_in = rdv;
            mid_in = last_idx >> 1;
            rd_addr = last_idx >> 1;
            if (key_ff > rdv) begin
               found_in = 1'b0;
               pos_in = '0;
               state_in = ST_DONE;
            end else if ({1'b0, last_idx} > {{AW{1'b0}}, 1'b1}) begin
               state_in = ST_PROBE;
            end else begin
               found_in = (key_ff == rdv);
               pos_in = (key_ff == rdv) ? last_idx : '0;
               state_in = ST_DONE;
            end
         end
         ST_PROBE: begin
            lo_in = lo_n;
            hi_in = hi_n;
            hival_in = hv_n;
            mid_in = sum_n[AW:1];
            rd_addr = sum_n[AW:1];
            if (({1'b0, lo_n} + {{AW{1'b0}}, 1'b1}) >= {1'b0, hi_n}) begin
               found_in = (hv_n == key_ff);
               pos_in = (hv_n == key_ff) ? hi_n : '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign pos_wide = 32'(pos_ff);
   assign res_item.found = found_ff;
   assign res_item.position = pos_wide[INDEX_W-1:0];

endmodule

// File: hdl/sorted_table_binary_search.sv
// Load item: accepted in any idle cycle and written to the table at that edge; one per cycle.
// Search item: one table read per cycle; the engine reads the first entry, then the last one,
// then probes midpoints until the range closes; the result goes to the output register and
// the next item is then accepted; a key outside the table ends it at the first or last read.
// A result waiting in the output register holds the search engine and the input.
// Reset is synchronous: control state is cleared and entry_count set to 1024; the table is not.
module sorted_table_binary_search #(
   parameter int DEPTH = sts_pkg::DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input sts_pkg::req_item_type req_item,
   output logic rsp_valid,
   input logic rsp_ready,
   output sts_pkg::rsp_item_type rsp_item,
   input logic csr_wr_en,
   input logic [sts_pkg::COUNT_W-1:0] csr_wr_data
);

   import sts_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [COUNT_W-1:0] entry_count_ff;
   logic rsp_valid_ff;
   rsp_item_type rsp_item_ff;

   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [AW-1:0] rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic res_valid;
   rsp_item_type res_item;
   logic res_free;

   assign res_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= ENTRY_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            entry_count_ff <= csr_wr_data;
         end
         if (res_valid && res_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (res_valid && res_free) begin
         rsp_item_ff <= res_item;
      end
   end

   sts_ram #(
      .WIDTH(DATA_W),
      .DEPTH(DEPTH)
   ) u_table (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(1'b1),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   sts_search #(
      .DEPTH(DEPTH)
   ) u_search (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item(req_item),
      .entry_count(entry_count_ff),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .res_valid(res_valid),
      .res_item(res_item),
      .res_free(res_free)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

endmodule

// File: bench/search_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the sorted table binary search block: keeps its own copy of the
// table and the entry count, predicts every search result and compares it with the block.
// Depends on sts_pkg for the item types, widths and reset value.
module search_result_checker #(
   parameter int DEPTH = sts_pkg::DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input sts_pkg::req_item_type req_item,
   input logic rsp_valid,
   input logic rsp_ready,
   input sts_pkg::rsp_item_type rsp_item,
   input logic csr_wr_en,
   input logic [sts_pkg::COUNT_W-1:0] csr_wr_data,
   output int unsigned fail_count,
   output int unsigned results_pending,
   output int unsigned searches_checked,
   output int unsigned hits_seen
);

   import sts_pkg::*;

   logic signed [DATA_W-1:0] table_mirror [DEPTH];
   logic [COUNT_W-1:0] entry_limit;
   rsp_item_type expected_hits [$];

   function automatic rsp_item_type lower_bound_lookup(input logic signed [DATA_W-1:0] key);
      int unsigned span;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      rsp_item_type outcome;
      span = entry_limit;
      if (span == 0) begin
         span = 1;
      end
      if (span > DEPTH) begin
         span = DEPTH;
      end
      outcome = '0;
      if (key == table_mirror[0]) begin
         outcome.found = 1'b1;
      end else if (key > table_mirror[0] && key <= table_mirror[span - 1]) begin
         lo = 0;
         hi = span - 1;
         while (lo + 1 < hi) begin
            mid = (lo + hi) / 2;
            if (key > table_mirror[mid]) begin
               lo = mid;
            end else begin
               hi = mid;
            end
         end
         if (table_mirror[hi] == key) begin
            outcome.found = 1'b1;
            outcome.position = INDEX_W'(hi);
         end
      end
      return outcome;
   endfunction

   always @(posedge clock) begin : watch_channels
      rsp_item_type want;
      if (reset) begin
         entry_limit = ENTRY_COUNT_RESET;
         expected_hits.delete();
      end else begin
         if (csr_wr_en) begin
            entry_limit = csr_wr_data;
         end
         if (req_valid && req_ready) begin
            if (req_item.req_type == REQ_LOAD) begin
               table_mirror[req_item.entry_index] = req_item.data_value;
            end else begin
               expected_hits.push_back(lower_bound_lookup(req_item.data_value));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_hits.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result item, expected none, actual found=%0b position=%0d",
                        $time, rsp_item.found, rsp_item.position);
            end else begin
               want = expected_hits.pop_front();
               searches_checked++;
               if (want.found) begin
                  hits_seen++;
               end
               if (rsp_item.found !== want.found || rsp_item.position !== want.position) begin
                  fail_count++;
                  $display("%0t: expected found=%0b position=%0d, actual found=%0b position=%0d",
                           $time, want.found, want.position, rsp_item.found, rsp_item.position);
               end
            end
         end
      end
      results_pending = expected_hits.size();
   end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the sorted table binary search block: clock, reset, entry count
// writes, table loads and search items under several idling phases, and the verdict.
// Depends on sts_pkg, sorted_table_binary_search and search_result_checker.
module tb_top;
   import sts_pkg::*;

   typedef enum int unsigned {
      MODE_FREE,
      MODE_SEND_IDLE,
      MODE_RECV_STALL,
      MODE_BOTH
   } idle_mode_type;

   localparam int TABLE_DEPTH = DEPTH_DEFAULT;
   localparam int SETTLE_CYCLES = 32;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7fff_ffff;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_item_type rsp_item;
   logic csr_wr_en = 1'b0;
   logic [COUNT_W-1:0] csr_wr_data = '0;
   logic rsp_hold = 1'b0;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned cycle_count = 0;
   int unsigned loads_sent = 0;
   int unsigned settings_used = 0;
   int unsigned fail_count;
   int unsigned results_pending;
   int unsigned searches_checked;
   int unsigned hits_seen;
   logic signed [DATA_W-1:0] loaded [TABLE_DEPTH];

   sorted_table_binary_search #(
      .DEPTH(TABLE_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   search_result_checker #(
      .DEPTH(TABLE_DEPTH)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .fail_count(fail_count),
      .results_pending(results_pending),
      .searches_checked(searches_checked),
      .hits_seen(hits_seen)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(negedge clock) begin
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sorted_table_binary_search: mismatch");
         $finish;
      end
   end

   task automatic send_req(input req_kind_type kind, input logic [INDEX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] value);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_item <= '{req_type: kind, entry_index: idx, data_value: value};
      req_valid <= 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   task automatic load_entry(input int unsigned idx, input logic signed [DATA_W-1:0] value);
      send_req(REQ_LOAD, INDEX_W'(idx), value);
      loaded[idx] = value;
      loads_sent++;
   endtask

   task automatic search_key(input logic signed [DATA_W-1:0] key);
      send_req(REQ_SEARCH, INDEX_W'($urandom), key);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (results_pending == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_entry_count(input logic [COUNT_W-1:0] value);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   task automatic hold_responses(input int unsigned cycles);
      rsp_hold <= 1'b1;
      repeat (cycles) @(negedge clock);
      rsp_hold <= 1'b0;
   endtask

   task automatic set_mode(input idle_mode_type mode);
      unique case (mode)
         MODE_SEND_IDLE: begin
            send_idle_pct = 87;
            recv_stall_pct = 0;
         end
         MODE_RECV_STALL: begin
            send_idle_pct = 0;
            recv_stall_pct = 87;
         end
         MODE_BOTH: begin
            send_idle_pct = 35;
            recv_stall_pct = 35;
         end
         MODE_FREE: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
      endcase
   endtask

   function automatic int unsigned span_of(input logic [COUNT_W-1:0] value);
      if (value == 0) begin
         return 1;
      end
      if (value > TABLE_DEPTH) begin
         return TABLE_DEPTH;
      end
      return value;
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_key(input int unsigned span);
      int unsigned roll;
      logic signed [DATA_W-1:0] probe;
      roll = $urandom_range(99);
      probe = loaded[$urandom_range(span - 1)];
      if (roll < 40) begin
         return probe;
      end
      if (roll < 55) begin
         return $urandom_range(1) ? probe + 1 : probe - 1;
      end
      if (roll < 65) begin
         return loaded[0] - 1 - $urandom_range(3);
      end
      if (roll < 75) begin
         return loaded[span - 1] + 1 + $urandom_range(3);
      end
      if (roll < 82) begin
         return $urandom_range(1) ? KEY_MIN : KEY_MAX;
      end
      return $urandom;
   endfunction

   // Dense tables repeat values often; wide ones spread over the whole signed range.
   task automatic fill_table(input int unsigned span, input bit dense, input bit scramble);
      logic signed [DATA_W-1:0] values [TABLE_DEPTH];
      longint acc;
      int unsigned step_cap;
      bit backward;
      step_cap = dense ? 2 : 32'((64'h1_0000_0000 / span) - 1);
      if (dense) begin
         acc = longint'($urandom_range(2000)) - 1000;
      end else begin
         acc = -64'sd2147483648 + longint'($urandom_range(step_cap));
      end
      for (int unsigned i = 0; i < span; i++) begin
         values[i] = scramble ? $urandom : acc[DATA_W-1:0];
         acc += $urandom_range(step_cap);
      end
      backward = $urandom_range(1);
      for (int unsigned i = 0; i < span; i++) begin
         if (backward) begin
            load_entry(span - 1 - i, values[span - 1 - i]);
         end else begin
            load_entry(i, values[i]);
         end
      end
   endtask

   task automatic run_phase(input logic [COUNT_W-1:0] count, input bit reload, input bit dense,
                            input bit scramble, input int unsigned searches,
                            input idle_mode_type mode, input bit hold);
      int unsigned span;
      span = span_of(count);
      write_entry_count(count);
      set_mode(mode);
      if (reload) begin
         fill_table(span, dense, scramble);
      end
      if (hold) begin
         fork
            hold_responses(HOLD_CYCLES);
         join_none
      end
      for (int unsigned n = 0; n < searches; n++) begin
         if ($urandom_range(99) < 15) begin
            if (scramble) begin
               load_entry($urandom_range(TABLE_DEPTH - 1), $urandom);
            end else if (span < TABLE_DEPTH) begin
               load_entry($urandom_range(TABLE_DEPTH - 1, span), $urandom);
            end
         end
         search_key(pick_key(span));
      end
   endtask

   // Full-depth entry counts with only the first and last entries loaded: every key stays at
   // or below the first entry or above the last, so no other entry is ever probed.
   task automatic edge_phase(input logic [COUNT_W-1:0] count, input int unsigned searches,
                             input idle_mode_type mode);
      logic signed [DATA_W-1:0] low_value;
      logic signed [DATA_W-1:0] high_value;
      logic signed [DATA_W-1:0] key;
      int unsigned roll;
      write_entry_count(count);
      set_mode(mode);
      low_value = -32'sd1000 - $signed(DATA_W'($urandom_range(1048576)));
      high_value = 32'sd1000 + $signed(DATA_W'($urandom_range(1048576)));
      load_entry(0, low_value);
      load_entry(TABLE_DEPTH - 1, high_value);
      for (int unsigned n = 0; n < searches; n++) begin
         roll = $urandom_range(99);
         if (roll < 30) begin
            key = low_value;
         end else if (roll < 55) begin
            key = low_value - 32'sd1 - $signed(DATA_W'($urandom_range(1000)));
         end else if (roll < 70) begin
            key = KEY_MIN;
         end else if (roll < 90) begin
            key = high_value + 32'sd1 + $signed(DATA_W'($urandom_range(1000)));
         end else begin
            key = KEY_MAX;
         end
         search_key(key);
      end
   endtask

   initial begin
      int unsigned roll;
      logic [COUNT_W-1:0] count;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_entry_count(11'd4);
      load_entry(0, KEY_MIN);
      load_entry(1, 5);
      load_entry(2, 5);
      load_entry(3, KEY_MAX);
      load_entry(TABLE_DEPTH - 1, 32'sh5555_5555);
      search_key(KEY_MIN);
      search_key(KEY_MAX);
      search_key(5);
      search_key(4);
      search_key(6);
      search_key(0);

      write_entry_count(11'd0);
      load_entry(0, 100);
      load_entry(512, $urandom);
      search_key(100);
      search_key(99);
      search_key(101);

      run_phase(11'd100, 1'b1, 1'b0, 1'b0, 60, MODE_FREE, 1'b0);
      edge_phase(11'd2047, 20, MODE_SEND_IDLE);
      edge_phase(11'd1024, 20, MODE_BOTH);
      for (int unsigned k = 0; k < 10; k++) begin
         roll = $urandom_range(99);
         if (roll < 15) begin
            count = 11'd1;
         end else if (roll < 80) begin
            count = COUNT_W'($urandom_range(40, 2));
         end else begin
            count = COUNT_W'($urandom_range(96, 41));
         end
         run_phase(count, 1'b1, $urandom_range(1), k == 5 || $urandom_range(99) < 10, 20,
                   idle_mode_type'((k + 2) % 4), k == 2);
      end
      settle();

      $display("Checked %0d search results (%0d hits) after %0d table loads over %0d entry counts.",
               searches_checked, hits_seen, loads_sent, settings_used);
      $display("Phases ran free, with sender gaps, receiver stalls, both, and a %0d-cycle hold.",
               HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("sorted_table_binary_search: match");
      end else begin
         $display("sorted_table_binary_search: mismatch");
      end
      $finish;
   end

endmodule
